### rtl/core/hcp_pkg.sv
// Shared types, constants and helper functions for the chunked HTTP response parser.
package hcp_pkg;

   localparam int LINE_POS_MAX = 256;
   localparam int LINE_POS_W   = $clog2(LINE_POS_MAX + 1);
   localparam int COUNT_WIDTH  = 32;
   localparam int ACC_W        = 32;
   localparam int WIDE_W       = ACC_W + 4;

   localparam int LEN_HTTP  = 5;
   localparam int LEN_CLEN  = 16;
   localparam int LEN_CHUNK = 26;
   localparam int LEN_CLOSE = 17;
   localparam int PAT_W     = 8 * LEN_CHUNK;

   localparam logic [PAT_W-1:0] PAT_HTTP  = PAT_W'("HTTP/");
   localparam logic [PAT_W-1:0] PAT_CLEN  = PAT_W'("Content-Length: ");
   localparam logic [PAT_W-1:0] PAT_CHUNK = PAT_W'("Transfer-Encoding: chunked");
   localparam logic [PAT_W-1:0] PAT_CLOSE = PAT_W'("Connection: close");

   localparam logic [9:0]  STATUS_MAX       = 10'd999;
   localparam logic [9:0]  STATUS_MALFORMED = 10'd603;
   localparam logic [9:0]  STATUS_CONTINUE  = 10'd100;
   localparam logic [WIDE_W-1:0] DEC_MAX    = WIDE_W'(32'h7FFF_FFFF);
   localparam logic [WIDE_W-1:0] COUNT_MAX  = (WIDE_W'(1) << COUNT_WIDTH) - WIDE_W'(1);

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;

   // prefix flag positions
   localparam int F_HTTP  = 0;
   localparam int F_CLEN  = 1;
   localparam int F_CHUNK = 2;
   localparam int F_CLOSE = 3;

   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_DIGITS = 2'd1,
      PH_STOP   = 2'd3
   } num_phase_type;

   typedef struct packed {
      num_phase_type    phase;
      logic [ACC_W-1:0] accum;
   } num_type;

   typedef struct packed {
      logic [LINE_POS_W-1:0]  line_pos;
      logic [3:0]             flags;
      logic                   space_seen;
      num_type                num;
      logic [9:0]             status;
      logic [30:0]            length;
      logic [COUNT_WIDTH-1:0] to_go;
      logic                   chunked;
      logic                   size_next;
      logic                   close;
      logic                   done;
      logic                   malformed;
   } hcp_state_type;

   typedef struct packed {
      logic        body_valid;
      logic [7:0]  body_byte;
      logic        done_res;
      logic [9:0]  http_status;
      logic        malformed;
      logic [30:0] content_length;
      logic        conn_close;
      logic        chunked_mode;
   } hcp_rsp_type;

   function automatic hcp_state_type reset_state();
      hcp_state_type s;
      s = '0;
      s.flags     = 4'hF;
      s.num.phase = PH_SKIP;
      return s;
   endfunction

   // True when c is the character at position pos of a pattern of length len.
   function automatic logic pat_hit(logic [PAT_W-1:0] pat, int len,
                                    logic [LINE_POS_W-1:0] pos, logic [7:0] c);
      logic hit;
      hit = 1'b0;
      if (int'(pos) < len) begin
         hit = (pat[8 * (len - 1 - int'(pos)) +: 8] == c);
      end
      return hit;
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
   endfunction

   // One byte into the number accumulator, decimal or hex, saturating.
   function automatic num_type feed_number(num_type n, logic [7:0] c, logic hex);
      num_type          r;
      logic [7:0]       t;
      logic             dv;
      logic [WIDE_W-1:0] v;
      r  = n;
      t  = 8'd0;
      dv = 1'b0;
      v  = '0;
      if (n.phase != PH_STOP) begin
         if (n.phase == PH_SKIP && is_blank(c)) begin
            r = n;
         end else if (n.phase == PH_SKIP && !hex && c == CH_PLUS) begin
            r.phase = PH_DIGITS;
         end else begin
            if (c >= "0" && c <= "9") begin
               t  = c - 8'h30;
               dv = 1'b1;
            end else if (hex && c >= "a" && c <= "f") begin
               t  = c - 8'h57;
               dv = 1'b1;
            end else if (hex && c >= "A" && c <= "F") begin
               t  = c - 8'h37;
               dv = 1'b1;
            end
            if (!dv) begin
               r.phase = PH_STOP;
            end else begin
               r.phase = PH_DIGITS;
               if (hex) begin
                  v = {n.accum, 4'b0000} + WIDE_W'(t[3:0]);
                  if (v > COUNT_MAX) v = COUNT_MAX;
               end else begin
                  v = ({4'b0000, n.accum} << 3) + ({4'b0000, n.accum} << 1)
                      + WIDE_W'(t[3:0]);
                  if (v > DEC_MAX) v = DEC_MAX;
               end
               r.accum = v[ACC_W-1:0];
            end
         end
      end
      return r;
   endfunction

endpackage

### rtl/core/hcp_step.sv
// Next parse state and result for one accepted beat.
module hcp_step import hcp_pkg::*; (
   input  hcp_state_type cur,
   input  logic          cmd,
   input  logic [7:0]    rx_byte,
   output hcp_state_type nxt,
   output hcp_rsp_type   rsp
);

   logic              body;
   logic [ACC_W-1:0]  v;
   logic [WIDE_W-1:0] len_wide;

   always_comb begin
      nxt      = cur;
      body     = 1'b0;
      v        = cur.num.accum;
      len_wide = WIDE_W'(cur.length);
      if (!cmd) begin
         nxt = reset_state();
      end else if (!cur.done) begin
         if (cur.to_go != '0) begin
            // body beat: count down, finish on the last byte outside chunked mode
            nxt.to_go = cur.to_go - COUNT_WIDTH'(1);
            body      = 1'b1;
            if (cur.to_go == COUNT_WIDTH'(1) && !cur.chunked) nxt.done = 1'b1;
         end else if (rx_byte == CH_LF) begin
            if (cur.size_next) begin
               nxt.to_go     = v[COUNT_WIDTH-1:0];
               nxt.size_next = 1'b0;
               if (v == '0) nxt.chunked = 1'b0;
            end
            if (cur.line_pos == '0) begin
               nxt.to_go = (len_wide > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH-1:0]
                                                  : len_wide[COUNT_WIDTH-1:0];
               nxt.size_next = nxt.chunked;
               if (cur.length == '0 && !nxt.chunked && cur.status != STATUS_CONTINUE)
                  nxt.done = 1'b1;
            end else if (cur.flags[F_HTTP] && int'(cur.line_pos) >= LEN_HTTP) begin
               if (!cur.space_seen) begin
                  nxt.status    = STATUS_MALFORMED;
                  nxt.malformed = 1'b1;
                  nxt.done      = 1'b1;
               end else begin
                  nxt.status = (v > ACC_W'(STATUS_MAX)) ? STATUS_MAX : v[9:0];
               end
            end else if (cur.flags[F_CLEN] && int'(cur.line_pos) >= LEN_CLEN) begin
               nxt.length = v[30:0];
            end else if (cur.flags[F_CHUNK] && int'(cur.line_pos) == LEN_CHUNK) begin
               nxt.chunked = 1'b1;
            end else if (cur.flags[F_CLOSE] && int'(cur.line_pos) == LEN_CLOSE) begin
               nxt.close = 1'b1;
            end
            // start the next line
            nxt.line_pos   = '0;
            nxt.flags      = nxt.size_next ? 4'h0 : 4'hF;
            nxt.space_seen = 1'b0;
            nxt.num.phase  = PH_SKIP;
            nxt.num.accum  = '0;
         end else if (rx_byte != CH_CR) begin
            if (cur.size_next) begin
               nxt.num = feed_number(cur.num, rx_byte, 1'b1);
            end else begin
               if (cur.flags[F_HTTP]) begin
                  if (int'(cur.line_pos) < LEN_HTTP) begin
                     nxt.flags[F_HTTP] = pat_hit(PAT_HTTP, LEN_HTTP, cur.line_pos, rx_byte);
                  end else if (!cur.space_seen) begin
                     if (rx_byte == CH_SPACE) nxt.space_seen = 1'b1;
                  end else begin
                     nxt.num = feed_number(cur.num, rx_byte, 1'b0);
                  end
               end
               if (cur.flags[F_CLEN]) begin
                  if (int'(cur.line_pos) < LEN_CLEN) begin
                     nxt.flags[F_CLEN] = pat_hit(PAT_CLEN, LEN_CLEN, cur.line_pos, rx_byte);
                  end else begin
                     nxt.num = feed_number(nxt.num, rx_byte, 1'b0);
                  end
               end
               nxt.flags[F_CHUNK] = cur.flags[F_CHUNK]
                                    & pat_hit(PAT_CHUNK, LEN_CHUNK, cur.line_pos, rx_byte);
               nxt.flags[F_CLOSE] = cur.flags[F_CLOSE]
                                    & pat_hit(PAT_CLOSE, LEN_CLOSE, cur.line_pos, rx_byte);
            end
            if (int'(cur.line_pos) < LINE_POS_MAX)
               nxt.line_pos = cur.line_pos + LINE_POS_W'(1);
         end
      end
   end

   always_comb begin
      rsp.body_valid     = body;
      rsp.body_byte      = body ? rx_byte : 8'd0;
      rsp.done_res       = nxt.done;
      rsp.http_status    = nxt.status;
      rsp.malformed      = nxt.malformed;
      rsp.content_length = nxt.length;
      rsp.conn_close     = nxt.close;
      rsp.chunked_mode   = nxt.chunked;
   end

endmodule

### rtl/core/http_response_chunked_parser.sv
// Top level of the HTTP/1.1 response parser with chunked transfer decoding.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  req_cmd, req_rx_byte
//   rsp_      out        rsp_valid / rsp_ready  body, done, status, length, flags
//
// One beat in, one beat out. A byte is taken every cycle while req_ready is
// high: the parse state is updated in the cycle of acceptance and the result
// lands in the output register, or in the skid register while it is stalled.
// A skid register behind the output register lets req_ready stay high for one
// extra beat while rsp_ready is low; after that req_ready drops until drained.
// Synchronous active-high reset clears the parse state to the start-of-response
// state and empties both result registers.
module http_response_chunked_parser import hcp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_body_valid,
   output logic [7:0]  rsp_body_byte,
   output logic        rsp_done_res,
   output logic [9:0]  rsp_http_status,
   output logic        rsp_malformed,
   output logic [30:0] rsp_content_length,
   output logic        rsp_conn_close,
   output logic        rsp_chunked_mode
);

   hcp_state_type state_ff, state_in;
   hcp_rsp_type   step_rsp;
   hcp_rsp_type   out_ff, out_in;
   hcp_rsp_type   skid_ff, skid_in;
   logic          out_valid_ff, out_valid_in;
   logic          skid_valid_ff, skid_valid_in;
   logic          accept;
   logic          drain;
   hcp_state_type step_state;

   hcp_step u_step (
      .cur     (state_ff),
      .cmd     (req_cmd),
      .rx_byte (req_rx_byte),
      .nxt     (step_state),
      .rsp     (step_rsp)
   );

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign drain     = out_valid_ff && rsp_ready;

   // Advance the parse state only on an accepted beat.
   always_comb begin
      state_in = accept ? step_state : state_ff;
   end

   // Output register with one skid entry behind it.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (drain) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = step_rsp;
            out_valid_in = accept;
         end
      end else if (!out_valid_ff) begin
         out_in       = step_rsp;
         out_valid_in = accept;
      end else if (accept) begin
         // hold the new result behind the stalled one
         skid_in       = step_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= reset_state();
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_body_valid     = out_ff.body_valid;
   assign rsp_body_byte      = out_ff.body_byte;
   assign rsp_done_res       = out_ff.done_res;
   assign rsp_http_status    = out_ff.http_status;
   assign rsp_malformed      = out_ff.malformed;
   assign rsp_content_length = out_ff.content_length;
   assign rsp_conn_close     = out_ff.conn_close;
   assign rsp_chunked_mode   = out_ff.chunked_mode;

   // The skid entry is only ever filled behind a held output beat.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without output beat");

   // A start command leaves the parser not done.
   a_start_clears_done: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_cmd) |=> !state_ff.done)
      else $error("done still set after start command");

   // Body bytes come only from a length or an active chunk.
   a_body_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_body_valid) |-> (rsp_chunked_mode || rsp_content_length != '0))
      else $error("body byte without length or chunked mode");

   // A malformed status line always finishes the response.
   a_malformed_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_malformed) |-> rsp_done_res)
      else $error("malformed without done");

endmodule

### tb/hcp_response_checker.sv
// Scoreboard for the chunked HTTP response parser: predicts every result beat and compares it.
`timescale 1ns / 1ps
module hcp_response_checker import hcp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_body_valid,
   input  logic [7:0]  rsp_body_byte,
   input  logic        rsp_done_res,
   input  logic [9:0]  rsp_http_status,
   input  logic        rsp_malformed,
   input  logic [30:0] rsp_content_length,
   input  logic        rsp_conn_close,
   input  logic        rsp_chunked_mode,
   output int          failures,
   output int          pending,
   output int          checked,
   output int          body_beats
);

   localparam logic [31:0] DEC_LIMIT = 32'h7FFF_FFFF;
   localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_WIDTH) - 64'd1;

   // parser state as predicted
   logic [LINE_POS_W-1:0]  ln_pos;
   logic [3:0]             ln_flags;
   logic                   ln_space;
   num_phase_type          num_ph;
   logic [31:0]            num_acc;
   logic [9:0]             st_code;
   logic [30:0]            cl_value;
   logic [COUNT_WIDTH-1:0] body_left;
   logic                   chunked_on;
   logic                   size_line;
   logic                   close_seen;
   logic                   resp_done;
   logic                   status_bad;

   hcp_rsp_type expected_q[$];

   task automatic report(input string msg);
      failures++;
      if (failures <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   task automatic start_line();
      ln_pos   = '0;
      ln_flags = size_line ? 4'h0 : 4'hF;
      ln_space = 1'b0;
      num_ph   = PH_SKIP;
      num_acc  = '0;
   endtask

   task automatic clear_response();
      st_code    = '0;
      cl_value   = '0;
      body_left  = '0;
      chunked_on = 1'b0;
      size_line  = 1'b0;
      close_seen = 1'b0;
      resp_done  = 1'b0;
      status_bad = 1'b0;
      start_line();
   endtask

   function automatic logic blank_char(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
   endfunction

   // Accumulate one character of a decimal or hex number, saturating.
   task automatic take_digit(input logic [7:0] c, input logic hex);
      int d;
      longint unsigned v;
      d = -1;
      if (num_ph != PH_STOP && !(num_ph == PH_SKIP && blank_char(c))) begin
         if (num_ph == PH_SKIP && !hex && c == CH_PLUS) begin
            num_ph = PH_DIGITS;
         end else begin
            if (c >= "0" && c <= "9") d = int'(c) - 48;
            else if (hex && c >= "a" && c <= "f") d = int'(c) - 87;
            else if (hex && c >= "A" && c <= "F") d = int'(c) - 55;
            if (d < 0) begin
               num_ph = PH_STOP;
            end else begin
               num_ph = PH_DIGITS;
               if (hex) begin
                  v = 64'(num_acc) * 64'd16 + 64'(d);
                  if (v > COUNT_LIMIT) v = COUNT_LIMIT;
               end else begin
                  v = 64'(num_acc) * 64'd10 + 64'(d);
                  if (v > 64'(DEC_LIMIT)) v = 64'(DEC_LIMIT);
               end
               num_acc = v[31:0];
            end
         end
      end
   endtask

   task automatic try_pattern(input int flag, input string pat, input logic [7:0] c);
      if (ln_flags[flag]) begin
         if (int'(ln_pos) >= pat.len()) ln_flags[flag] = 1'b0;
         else if (8'(pat[int'(ln_pos)]) != c) ln_flags[flag] = 1'b0;
      end
   endtask

   task automatic line_char(input logic [7:0] c);
      if (size_line) begin
         take_digit(c, 1'b1);
      end else begin
         if (ln_flags[F_HTTP]) begin
            if (int'(ln_pos) < LEN_HTTP) try_pattern(F_HTTP, "HTTP/", c);
            else if (!ln_space) begin
               if (c == CH_SPACE) ln_space = 1'b1;
            end else take_digit(c, 1'b0);
         end
         if (ln_flags[F_CLEN]) begin
            if (int'(ln_pos) < LEN_CLEN) try_pattern(F_CLEN, "Content-Length: ", c);
            else take_digit(c, 1'b0);
         end
         try_pattern(F_CHUNK, "Transfer-Encoding: chunked", c);
         try_pattern(F_CLOSE, "Connection: close", c);
      end
      if (int'(ln_pos) < LINE_POS_MAX) ln_pos++;
   endtask

   task automatic line_done();
      logic [31:0] v;
      longint unsigned len;
      v = num_acc;
      if (size_line) begin
         body_left = COUNT_WIDTH'(v);
         size_line = 1'b0;
         if (v == 0) chunked_on = 1'b0;
      end
      if (ln_pos == 0) begin
         len = 64'(cl_value);
         if (len > COUNT_LIMIT) len = COUNT_LIMIT;
         body_left = COUNT_WIDTH'(len);
         size_line = chunked_on;
         if (cl_value == 0 && !chunked_on && st_code != STATUS_CONTINUE) resp_done = 1'b1;
      end else if (ln_flags[F_HTTP] && int'(ln_pos) >= LEN_HTTP) begin
         if (!ln_space) begin
            st_code    = STATUS_MALFORMED;
            status_bad = 1'b1;
            resp_done  = 1'b1;
         end else begin
            st_code = (v > 32'(STATUS_MAX)) ? STATUS_MAX : v[9:0];
         end
      end else if (ln_flags[F_CLEN] && int'(ln_pos) >= LEN_CLEN) begin
         cl_value = v[30:0];
      end else if (ln_flags[F_CHUNK] && int'(ln_pos) == LEN_CHUNK) begin
         chunked_on = 1'b1;
      end else if (ln_flags[F_CLOSE] && int'(ln_pos) == LEN_CLOSE) begin
         close_seen = 1'b1;
      end
      start_line();
   endtask

   task automatic predict(input logic cmd, input logic [7:0] c, output hcp_rsp_type r);
      logic body;
      body = 1'b0;
      if (!cmd) begin
         clear_response();
      end else if (!resp_done) begin
         if (body_left != 0) begin
            body_left--;
            body = 1'b1;
            if (body_left == 0 && !chunked_on) resp_done = 1'b1;
         end else if (c == CH_LF) begin
            line_done();
         end else if (c != CH_CR) begin
            line_char(c);
         end
      end
      r.body_valid     = body;
      r.body_byte      = body ? c : 8'h00;
      r.done_res       = resp_done;
      r.http_status    = st_code;
      r.malformed      = status_bad;
      r.content_length = cl_value;
      r.conn_close     = close_seen;
      r.chunked_mode   = chunked_on;
   endtask

   task automatic check_field(input string name, input longint unsigned got,
                              input longint unsigned want);
      if (got != want)
         report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h", checked, name, got, want));
   endtask

   initial begin
      failures   = 0;
      pending    = 0;
      checked    = 0;
      body_beats = 0;
      clear_response();
   end

   // results first: a result accepted now always belongs to an older request
   always @(posedge clock) begin : scoreboard
      hcp_rsp_type want;
      if (reset) begin
         expected_q.delete();
         clear_response();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report("result beat arrived with nothing expected");
            end else begin
               want = expected_q.pop_front();
               check_field("body_valid", rsp_body_valid, want.body_valid);
               check_field("body_byte", rsp_body_byte, want.body_byte);
               check_field("done_res", rsp_done_res, want.done_res);
               check_field("http_status", rsp_http_status, want.http_status);
               check_field("malformed", rsp_malformed, want.malformed);
               check_field("content_length", rsp_content_length, want.content_length);
               check_field("conn_close", rsp_conn_close, want.conn_close);
               check_field("chunked_mode", rsp_chunked_mode, want.chunked_mode);
               if (want.body_valid) body_beats++;
               checked++;
            end
         end
         if (req_valid && req_ready) begin
            predict(req_cmd, req_rx_byte, want);
            expected_q.push_back(want);
         end
      end
      pending = expected_q.size();
   end

endmodule

### tb/testbench.sv
// Top of the chunked HTTP response parser testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

   // request command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BYTE  = 1'b1;

   localparam int RANDOM_ITEMS   = 220;
   localparam int QUIET_TAIL     = 100;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES    = 48;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_cmd     = CMD_START;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_ready   = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic        rsp_body_valid;
   logic [7:0]  rsp_body_byte;
   logic        rsp_done_res;
   logic [9:0]  rsp_http_status;
   logic        rsp_malformed;
   logic [30:0] rsp_content_length;
   logic        rsp_conn_close;
   logic        rsp_chunked_mode;

   int mismatches;
   int pending;
   int results_checked;
   int body_beats;

   logic [7:0] stream_q[$];       // bytes of the response being built
   int beats_sent        = 0;
   int responses         = 0;
   int chunked_responses = 0;
   int quiet_cycles      = 0;
   bit idle_on           = 1'b1;  // random gaps and stalls allowed
   bit hold_pending      = 1'b0;  // ask the receiver for one long hold

   always #4 clock = ~clock;

   http_response_chunked_parser i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_body_valid     (rsp_body_valid),
      .rsp_body_byte      (rsp_body_byte),
      .rsp_done_res       (rsp_done_res),
      .rsp_http_status    (rsp_http_status),
      .rsp_malformed      (rsp_malformed),
      .rsp_content_length (rsp_content_length),
      .rsp_conn_close     (rsp_conn_close),
      .rsp_chunked_mode   (rsp_chunked_mode)
   );

   hcp_response_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_body_valid     (rsp_body_valid),
      .rsp_body_byte      (rsp_body_byte),
      .rsp_done_res       (rsp_done_res),
      .rsp_http_status    (rsp_http_status),
      .rsp_malformed      (rsp_malformed),
      .rsp_content_length (rsp_content_length),
      .rsp_conn_close     (rsp_conn_close),
      .rsp_chunked_mode   (rsp_chunked_mode),
      .failures           (mismatches),
      .pending            (pending),
      .checked            (results_checked),
      .body_beats         (body_beats)
   );

   // Watchdog: count cycles in which no beat moves on either channel, and
   // give up once the parser has been silent for far longer than any stall.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("http_response_chunked_parser regression: fail");
         $finish;
      end
   end

   // Result sink: drive rsp_ready at the falling edge. Stall in bursts while
   // idling is on, and serve one long hold on request so that the output and
   // skid registers fill and req_ready drops.
   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (hold_pending) begin
            hold_pending = 1'b0;
            stall_left   = HOLD_CYCLES - 1;
            rsp_ready   <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one beat. Optionally drop valid for a burst first, with junk on the
   // byte lane, then hold the beat until it is taken at a rising edge.
   task automatic send_beat(input logic cmd, input logic [7:0] b);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 11);
      repeat (gap) begin
         @(negedge clock);
         req_valid   <= 1'b0;
         req_rx_byte <= 8'($urandom);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   // Start a fresh response, then stream out every byte built so far.
   task automatic flush_response();
      send_beat(CMD_START, 8'($urandom));
      while (stream_q.size() > 0) send_beat(CMD_BYTE, stream_q.pop_front());
      responses++;
   endtask

   task automatic put_byte(input logic [7:0] b);
      stream_q.push_back(b);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) stream_q.push_back(8'(s[i]));
   endtask

   // Line ends: mostly CR LF, sometimes bare LF or a doubled CR.
   task automatic put_eol();
      case ($urandom_range(0, 3))
         0: put_text("\n");
         1: put_text("\r\r\n");
         default: put_text("\r\n");
      endcase
   endtask

   task automatic put_blank();
      case ($urandom_range(0, 3))
         0: put_byte(8'h20);
         1: put_byte(8'h09);
         2: put_byte(8'h0B);
         default: put_byte(8'h0C);
      endcase
   endtask

   // Decimal field; when odd forms are allowed, sometimes add blanks, a sign,
   // leading zeros, trailing garbage, or replace it by a saturating value.
   task automatic put_dec(input int unsigned n, input bit odd);
      int r;
      r = odd ? $urandom_range(0, 15) : 15;
      if (r == 0) repeat ($urandom_range(1, 3)) put_blank();
      if (r == 1) put_text("+");
      if (r == 2) put_text("-");
      if (r == 3) put_text("00");
      if (r == 4) begin
         put_byte(8'($urandom_range(49, 57)));
         repeat ($urandom_range(10, 14)) put_byte(8'($urandom_range(48, 57)));
      end else begin
         put_text($sformatf("%0d", n));
      end
      if (r == 5) put_text(";q");
   endtask

   // Hex chunk size with random letter case, now and then padded or blanked.
   task automatic put_hex(input int unsigned n);
      string s;
      logic [7:0] ch;
      s = $sformatf("%0h", n);
      if ($urandom_range(0, 7) == 0) put_blank();
      if ($urandom_range(0, 7) == 0) put_text("00");
      for (int i = 0; i < s.len(); i++) begin
         ch = 8'(s[i]);
         if (ch >= "a" && ch <= "f" && $urandom_range(0, 1) == 1) ch = ch - 8'd32;
         put_byte(ch);
      end
   endtask

   task automatic put_random_body(input int n);
      repeat (n) put_byte(8'($urandom_range(0, 255)));
   endtask

   // Header lines that must not match, plus the odd long line.
   task automatic put_noise_header();
      case ($urandom_range(0, 11))
         0: put_text("Content-Type: text/plain");
         1: begin
            put_text("X-Trace: ");
            repeat ($urandom_range(0, 12)) put_byte(8'($urandom_range(32, 126)));
         end
         2: begin
            put_text("Content-Length:");
            put_dec($urandom_range(0, 20), 1'b0);
         end
         3: put_text("Transfer-Encoding: chunkedx");
         4: put_text("Transfer-Encoding: Chunked");
         5: put_text("Connection: closed");
         6: put_text("Connection: keep-alive");
         7: put_text("HTTP1.1 200");
         8: put_text("Connection: clos");
         9: repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(14, 255)));
         10: begin
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(250, 300)) put_byte(8'($urandom_range(33, 126)));
            else
               put_text("Server: unit");
         end
         default: put_text("Content-Length");
      endcase
      put_eol();
   endtask

   task automatic put_status();
      case ($urandom_range(0, 19))
         0: put_text("HTTP/1.1");
         1: put_text("HTTP/");
         default: begin
            put_text("HTTP/1.1 ");
            put_dec($urandom_range(100, 599), 1'b1);
            if ($urandom_range(0, 1) == 1) put_text(" OK");
         end
      endcase
      put_eol();
   endtask

   // One random response: mostly well-formed length or chunked bodies with
   // random content, some interim 100 responses, some header-only ones, and
   // some plain garbage; now and then cut short by the next start.
   task automatic make_response();
      int kind;
      int n;
      int sz;
      kind = $urandom_range(0, 99);
      if (kind >= 92) begin
         put_random_body($urandom_range(5, 40));
      end else begin
         if (kind >= 82) begin
            put_text("HTTP/1.1 100 Continue");
            put_eol();
            put_eol();
         end
         put_status();
         repeat ($urandom_range(0, 1)) put_noise_header();
         if ($urandom_range(0, 3) == 0) begin
            put_text("Connection: close");
            put_eol();
         end
         if (kind < 40 || kind >= 82) begin
            n = $urandom_range(0, 12);
            put_text("Content-Length: ");
            put_dec(n, 1'b1);
            put_eol();
            repeat ($urandom_range(0, 1)) put_noise_header();
            put_eol();
            put_random_body(n);
         end else if (kind < 72) begin
            chunked_responses++;
            put_text("Transfer-Encoding: chunked");
            put_eol();
            put_eol();
            repeat ($urandom_range(0, 3)) begin
               sz = $urandom_range(1, 12);
               put_hex(sz);
               if ($urandom_range(0, 3) == 0) put_text(";ext=1");
               put_eol();
               put_random_body(sz);
               put_eol();
            end
            // terminate with an empty size line or with a zero chunk
            if ($urandom_range(0, 3) == 0) begin
               put_eol();
            end else begin
               put_text("0");
               put_eol();
               repeat ($urandom_range(0, 1)) put_noise_header();
               put_eol();
            end
         end else begin
            put_eol();
         end
         put_random_body($urandom_range(0, 3));
      end
      if ($urandom_range(0, 19) == 0) begin
         n = $urandom_range(0, stream_q.size());
         while (stream_q.size() > n) void'(stream_q.pop_back());
      end
   endtask

   // Directed responses: field extremes and the parser's corner cases.
   task automatic run_directed();
      // plain length body with byte extremes and a line feed inside, then
      // bytes after completion that must be ignored
      put_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\n");
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(8'h0A);
      put_text("zz");
      flush_response();
      // status line with no space after the version
      put_text("HTTP/1.0404\r\nabc");
      flush_response();
      put_text("HTTP/\n");
      flush_response();
      // interim 100 Continue, then the final status and a close header
      put_text("HTTP/1.1 100 Continue\r\n\r\nHTTP/1.1 204 No Content\r\n");
      put_text("Connection: close\r\n\r\n");
      flush_response();
      // saturating status and length, aborted by the next start
      put_text("HTTP/1.1 4294967296 X\r\nContent-Length: 99999999999\r\n\r\nabcd");
      flush_response();
      // negative length reads as zero; blanks and a plus sign are skipped
      put_text("HTTP/1.1 200 OK\nContent-Length: -5\nContent-Length: ");
      put_byte(8'h0B);
      put_byte(8'h0C);
      put_byte(8'h09);
      put_text("+7\n\nbody-7!");
      flush_response();
      // chunked body with an extension and mixed-case sizes
      put_text("HTTP/1.1 200 OK\r\nTransfer-Encoding: chunked\r\n\r\n");
      put_text("A;x=1\r\n0123456789\r\nc\r\nabcdefghijkl\r\n0\r\n\r\n");
      flush_response();
      // chunk size that saturates the body counter
      put_text("Transfer-Encoding: chunked\n\nFFFFFFFFFFF\nxyz");
      flush_response();
      // empty chunk size line ends the body
      put_text("HTTP/1.1 200 OK\nTransfer-Encoding: chunked\n\n\n");
      flush_response();
      // over-long line: line position saturates, matching still works
      put_text("HTTP/1.1 ");
      repeat (262) put_byte("7");
      put_text("\nConnection: close\n\n");
      flush_response();
   endtask

   initial begin : stimulus
      int idx;
      int base;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      idx  = 0;
      base = beats_sent;
      while (beats_sent - base < RANDOM_ITEMS) begin
         // no idling in the closing stretch; otherwise now and then a clean run
         if (beats_sent - base > RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
         else idle_on = ($urandom_range(0, 5) != 0);
         if (idx == 0 || idx == 2) hold_pending = 1'b1;
         if (idx == 1 || idx == 3) begin
            // pause the sender until every outstanding result is back
            @(negedge clock);
            req_valid <= 1'b0;
            wait (pending == 0);
         end
         make_response();
         flush_response();
         idx++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (4) @(posedge clock);

      $display("Run covered %0d responses (%0d chunked) over %0d request beats,",
               responses, chunked_responses, beats_sent);
      $display("with %0d result beats checked (%0d body bytes), gaps, stalls and holds.",
               results_checked, body_beats);
      if (mismatches == 0 && pending == 0) begin
         $display("http_response_chunked_parser regression: pass");
      end else begin
         $display("http_response_chunked_parser regression: fail");
      end
      $finish;
   end

endmodule
